// ===== hw/rtl/tmf_pkg.sv =====
// Package for the trapezoid membership unit: widths, types and register codes.
`default_nettype none
package tmf_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 15;
	localparam int OUT_WIDTH  = 16;
	localparam int APB_WIDTH  = 32;
	localparam int ADDR_WIDTH = 4;
	localparam int REG_IDX_W  = 2;
	localparam int LATENCY    = FRAC_BITS + 2;

	localparam logic [OUT_WIDTH-1:0] MEMB_ONE = OUT_WIDTH'(1) << FRAC_BITS;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CORNER_A = 2'd0,
		REG_CORNER_B = 2'd1,
		REG_CORNER_C = 2'd2,
		REG_CORNER_D = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_ZERO  = 2'd0,
		KIND_ONE   = 2'd1,
		KIND_SLOPE = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] a;
		logic signed [DATA_WIDTH-1:0] b;
		logic signed [DATA_WIDTH-1:0] c;
		logic signed [DATA_WIDTH-1:0] d;
	} corners_t;

	typedef struct packed {
		logic                  valid;
		kind_t                 kind;
		logic [DATA_WIDTH-1:0] rem;
		logic [DATA_WIDTH-1:0] den;
		logic [FRAC_BITS-1:0]  quot;
	} div_stage_t;

endpackage
`default_nettype wire

// ===== hw/rtl/trapezoid_membership_unit.sv =====
// Top level: corner registers, APB port, front stage, divider cell chain, result register.
`default_nettype none
// Takes one sample per clock (busy is never raised) and returns its Q1.15 trapezoid
// membership through one front stage, a chain of 15 divider cells
// (one quotient bit each) and the result register. done pulses for one cycle with
// membership; there is no back-pressure. Corners are written over APB at 0x0/0x4/0x8/0xC
// and must only change while no item is in flight.
module trapezoid_membership_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [tmf_pkg::DATA_WIDTH-1:0] sample,
	output logic                                     done,
	output logic        [tmf_pkg::OUT_WIDTH-1:0]     membership,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic   [tmf_pkg::ADDR_WIDTH-1:0]    paddr,
	input  wire logic   [tmf_pkg::APB_WIDTH-1:0]     pwdata,
	output logic        [tmf_pkg::APB_WIDTH-1:0]     prdata,
	output logic                                     pready
);
	import tmf_pkg::*;

	corners_t                  corners_q;
	reg_idx_t                  reg_idx;
	logic                      wr_en;
	logic [DATA_WIDTH-1:0]     rd_val;
	div_stage_t                chain [FRAC_BITS+1];
	logic [OUT_WIDTH-1:0]      memb_d;
	logic                      done_q;
	logic [OUT_WIDTH-1:0]      membership_q;

	assign busy    = 1'b0;
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_WIDTH-1:ADDR_WIDTH-REG_IDX_W]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corners_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CORNER_A: corners_q.a <= pwdata[DATA_WIDTH-1:0];
				REG_CORNER_B: corners_q.b <= pwdata[DATA_WIDTH-1:0];
				REG_CORNER_C: corners_q.c <= pwdata[DATA_WIDTH-1:0];
				REG_CORNER_D: corners_q.d <= pwdata[DATA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CORNER_A: rd_val = corners_q.a;
			REG_CORNER_B: rd_val = corners_q.b;
			REG_CORNER_C: rd_val = corners_q.c;
			REG_CORNER_D: rd_val = corners_q.d;
			default:      rd_val = '0;
		endcase
	end

	assign prdata = {{(APB_WIDTH-DATA_WIDTH){rd_val[DATA_WIDTH-1]}}, rd_val};

	tmf_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.sample   (sample),
		.corners  (corners_q),
		.stage_s1 (chain[0])
	);

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
		tmf_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.stage_in  (chain[i]),
			.stage_out (chain[i+1])
		);
	end

	always_comb begin
		case (chain[FRAC_BITS].kind)
			KIND_ONE:   memb_d = MEMB_ONE;
			KIND_SLOPE: memb_d = {{(OUT_WIDTH-FRAC_BITS){1'b0}}, chain[FRAC_BITS].quot};
			default:    memb_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain[FRAC_BITS].valid;
		end
	end

	always_ff @(posedge clk) begin
		membership_q <= memb_d;
	end

	assign done       = done_q;
	assign membership = membership_q;

	a_done_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching item");

	a_membership_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> membership <= MEMB_ONE)
		else $error("membership above one");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !busy)
		else $error("pipeline raised busy");

endmodule
`default_nettype wire

// ===== hw/rtl/tmf_classify.sv =====
// Front stage: region decision and slope numerator/denominator for one item.
`default_nettype none
module tmf_classify (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic signed [tmf_pkg::DATA_WIDTH-1:0] sample,
	input  wire tmf_pkg::corners_t               corners,
	output tmf_pkg::div_stage_t                  stage_s1
);
	import tmf_pkg::*;

	logic signed [DATA_WIDTH:0] y_minus_a;
	logic signed [DATA_WIDTH:0] b_minus_a;
	logic signed [DATA_WIDTH:0] d_minus_y;
	logic signed [DATA_WIDTH:0] d_minus_c;
	div_stage_t                 stage_d;

	assign y_minus_a = {sample[DATA_WIDTH-1], sample} - {corners.a[DATA_WIDTH-1], corners.a};
	assign b_minus_a = {corners.b[DATA_WIDTH-1], corners.b} - {corners.a[DATA_WIDTH-1], corners.a};
	assign d_minus_y = {corners.d[DATA_WIDTH-1], corners.d} - {sample[DATA_WIDTH-1], sample};
	assign d_minus_c = {corners.d[DATA_WIDTH-1], corners.d} - {corners.c[DATA_WIDTH-1], corners.c};

	always_comb begin
		stage_d.valid = in_valid;
		stage_d.quot  = '0;
		stage_d.rem   = '0;
		stage_d.den   = '0;
		if (sample <= corners.a || sample >= corners.d) begin
			stage_d.kind = KIND_ZERO;
		end else if (sample < corners.b) begin
			stage_d.kind = KIND_SLOPE;
			stage_d.rem  = y_minus_a[DATA_WIDTH-1:0];
			stage_d.den  = b_minus_a[DATA_WIDTH-1:0];
		end else if (sample <= corners.c) begin
			stage_d.kind = KIND_ONE;
		end else begin
			stage_d.kind = KIND_SLOPE;
			stage_d.rem  = d_minus_y[DATA_WIDTH-1:0];
			stage_d.den  = d_minus_c[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else begin
			stage_s1 <= stage_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tmf_div_cell.sv =====
// One restoring-division cell: yields one quotient bit and hands on the remainder.
`default_nettype none
module tmf_div_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tmf_pkg::div_stage_t  stage_in,
	output tmf_pkg::div_stage_t       stage_out
);
	import tmf_pkg::*;

	logic [DATA_WIDTH:0] shifted;
	logic [DATA_WIDTH:0] den_ext;
	logic [DATA_WIDTH:0] diff;
	logic                ge;

	assign shifted = {stage_in.rem, 1'b0};
	assign den_ext = {1'b0, stage_in.den};
	assign diff    = shifted - den_ext;
	assign ge      = shifted >= den_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_out <= '0;
		end else begin
			stage_out.valid <= stage_in.valid;
			stage_out.kind  <= stage_in.kind;
			stage_out.den   <= stage_in.den;
			stage_out.rem   <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
			stage_out.quot  <= {stage_in.quot[FRAC_BITS-2:0], ge};
		end
	end

endmodule
`default_nettype wire
